@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the delay line RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tcdl_pkg.sv @@
// Types, constants and helpers for the timestamped command delay line
package tcdl_pkg;

    localparam int HIST_DEPTH = 256;
    localparam int PTR_W      = $clog2(HIST_DEPTH);
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

    localparam int VEL_W   = 32;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 24;
    localparam int OFF_W   = DELAY_W + 1;
    localparam int SUM_W   = TIME_W + 2;

    localparam int TOL_US         = 1;
    localparam int KEEP_MARGIN_US = 1000000;
    localparam int KEEP_OFF_ADD   = KEEP_MARGIN_US + TOL_US + 1;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [TIME_W-1:0]       time_us;
        logic signed [VEL_W-1:0] linear;
        logic signed [VEL_W-1:0] angular;
    } entry_t;

    typedef struct packed {
        logic [TIME_W-1:0] entry_time;
        logic [OFF_W-1:0]  offset;
        logic [TIME_W-1:0] now;
    } cmp_req_t;

    function automatic ptr_t slot_add(ptr_t base, cnt_t k);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - PTR_W){1'b0}}, base} + {1'b0, k};
        if (sum >= (CNT_W + 1)'(HIST_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(HIST_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

@@ rtl/core/tcdl_ram.sv @@
// Generic single write port, single read port RAM with registered read
module tcdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/tcdl_cmp.sv @@
// Shared time comparator: entry_time + offset <= now + tolerance
module tcdl_cmp (
    input  tcdl_pkg::cmp_req_t req,
    output logic               le
);
    import tcdl_pkg::*;

    logic [SUM_W-1:0] lhs;
    logic [SUM_W-1:0] rhs;

    assign lhs = SUM_W'(req.entry_time) + SUM_W'(req.offset);
    assign rhs = SUM_W'(req.now) + SUM_W'(TOL_US);
    assign le  = (lhs <= rhs);

endmodule

@@ rtl/core/timestamped_command_delay_line_core.sv @@
// Top level: sequencer, history RAM and shared comparator of the delay line
//
//   channel | ports   | moves
//   --------+---------+---------------------------------------------
//   input   | s_*     | one command transaction (velocities, time, fault)
//   result  | m_*     | one delayed command transaction per input
//   config  | cfg_*   | delay register write, clears the history
//
// From acceptance to m_valid a command passes a check of the newest entry (skipped with an
// empty history), the append, a search from the newest entry back while the delay is active
// (until a hit, or a miss over all entries) and the pruning of the entries dropped.
// All steps share the one RAM read port and the one comparator. aresetn is synchronous,
// active low, and empties the history at once. Input is taken again once the result is
// loaded, while it may still wait on m_ready; a second finished result waits in done.
`include "assert_macros.svh"

module timestamped_command_delay_line_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [tcdl_pkg::VEL_W-1:0]   s_linear_velocity,
    input  logic signed [tcdl_pkg::VEL_W-1:0]   s_angular_velocity,
    input  logic [tcdl_pkg::TIME_W-1:0]         s_sample_time_us,
    input  logic                                s_fault_on,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [tcdl_pkg::VEL_W-1:0]   m_delayed_linear,
    output logic signed [tcdl_pkg::VEL_W-1:0]   m_delayed_angular,
    output logic [tcdl_pkg::TIME_W-1:0]         m_source_time_us,
    output logic                                m_delay_on,
    output logic signed [tcdl_pkg::VEL_W-1:0]   m_echo_linear,
    output logic signed [tcdl_pkg::VEL_W-1:0]   m_echo_angular,
    output logic                                m_ring_overflow,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcdl_pkg::DELAY_W-1:0]        cfg_delay_us
);
    import tcdl_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CHK    = 7'b0000010,
        ST_APPEND = 7'b0000100,
        ST_SRCH   = 7'b0001000,
        ST_PR_RD  = 7'b0010000,
        ST_PR_CMP = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [OFF_W-1:0]     keep_off_reg, keep_off_next;
    ptr_t                 oldest_reg, oldest_next;
    cnt_t                 count_reg, count_next;
    cnt_t                 k_reg, k_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 m_valid_reg, m_valid_next;

    logic signed [VEL_W-1:0] in_lin_reg, in_lin_next;
    logic signed [VEL_W-1:0] in_ang_reg, in_ang_next;
    logic [TIME_W-1:0]       now_reg, now_next;
    logic                    active_reg, active_next;
    logic                    ovf_reg, ovf_next;
    logic signed [VEL_W-1:0] res_lin_reg, res_lin_next;
    logic signed [VEL_W-1:0] res_ang_reg, res_ang_next;
    logic [TIME_W-1:0]       res_time_reg, res_time_next;

    logic signed [VEL_W-1:0] m_lin_reg, m_ang_reg, m_echo_lin_reg, m_echo_ang_reg;
    logic [TIME_W-1:0]       m_time_reg;
    logic                    m_delay_on_reg, m_ovf_reg;

    logic     out_load;
    logic     ram_we;
    ptr_t     wr_addr;
    ptr_t     rd_addr;
    entry_t   wr_entry;
    entry_t   rd_entry;
    cmp_req_t cmp_req;
    logic     cmp_le;
    logic     full;
    ptr_t     app_oldest;
    cnt_t     app_count;

    tcdl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    tcdl_cmp u_cmp (
        .req (cmp_req),
        .le  (cmp_le)
    );

    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);

    assign full       = (count_reg == CNT_W'(HIST_DEPTH));
    assign app_oldest = full ? slot_add(oldest_reg, CNT_W'(1)) : oldest_reg;
    assign app_count  = full ? CNT_W'(HIST_DEPTH - 1) : count_reg;

    assign wr_addr          = slot_add(app_oldest, app_count);
    assign wr_entry.time_us = now_reg;
    assign wr_entry.linear  = in_lin_reg;
    assign wr_entry.angular = in_ang_reg;

    always_comb begin
        state_next    = state_reg;
        delay_next    = delay_reg;
        keep_off_next = keep_off_reg;
        oldest_next   = oldest_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        rd_pend_next  = rd_pend_reg;
        in_lin_next   = in_lin_reg;
        in_ang_next   = in_ang_reg;
        now_next      = now_reg;
        active_next   = active_reg;
        ovf_next      = ovf_reg;
        res_lin_next  = res_lin_reg;
        res_ang_next  = res_ang_reg;
        res_time_next = res_time_reg;
        ram_we        = 1'b0;
        rd_addr       = '0;
        cmp_req.entry_time = rd_entry.time_us;
        cmp_req.now        = now_reg;
        cmp_req.offset = '0;
        out_load      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    delay_next    = cfg_delay_us;
                    keep_off_next = OFF_W'(cfg_delay_us) + OFF_W'(KEEP_OFF_ADD);
                    oldest_next   = '0;
                    count_next    = '0;
                end else if (s_valid) begin
                    in_lin_next   = s_linear_velocity;
                    in_ang_next   = s_angular_velocity;
                    now_next      = s_sample_time_us;
                    active_next   = s_fault_on && (delay_reg != '0);
                    ovf_next      = 1'b0;
                    res_lin_next  = s_linear_velocity;
                    res_ang_next  = s_angular_velocity;
                    res_time_next = s_sample_time_us;
                    if (count_reg != '0) begin
                        rd_addr    = slot_add(oldest_reg, count_reg - CNT_W'(1));
                        state_next = ST_CHK;
                    end else begin
                        state_next = ST_APPEND;
                    end
                end
            end
            ST_CHK: begin
                if (!cmp_le) begin
                    oldest_next = '0;
                    count_next  = '0;
                end
                state_next = ST_APPEND;
            end
            ST_APPEND: begin
                ram_we       = 1'b1;
                oldest_next  = app_oldest;
                count_next   = app_count + CNT_W'(1);
                ovf_next     = full;
                k_next       = app_count + CNT_W'(1);
                rd_pend_next = 1'b0;
                state_next   = active_reg ? ST_SRCH : ST_PR_RD;
            end
            ST_SRCH: begin
                cmp_req.offset = OFF_W'(delay_reg);
                if (rd_pend_reg && cmp_le) begin
                    res_lin_next  = rd_entry.linear;
                    res_ang_next  = rd_entry.angular;
                    res_time_next = rd_entry.time_us;
                    state_next    = ST_PR_RD;
                end else if (k_reg == '0 && !rd_pend_reg) begin
                    res_lin_next  = '0;
                    res_ang_next  = '0;
                    res_time_next = now_reg;
                    state_next    = ST_PR_RD;
                end else if (k_reg != '0) begin
                    rd_addr      = slot_add(oldest_reg, k_reg - CNT_W'(1));
                    k_next       = k_reg - CNT_W'(1);
                    rd_pend_next = 1'b1;
                end else begin
                    rd_pend_next = 1'b0;
                end
            end
            ST_PR_RD: begin
                if (count_reg > CNT_W'(2)) begin
                    rd_addr    = slot_add(oldest_reg, CNT_W'(1));
                    state_next = ST_PR_CMP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PR_CMP: begin
                cmp_req.offset = keep_off_reg;
                if (cmp_le) begin
                    oldest_next = slot_add(oldest_reg, CNT_W'(1));
                    count_next  = count_reg - CNT_W'(1);
                    state_next  = ST_PR_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            delay_reg    <= '0;
            keep_off_reg <= OFF_W'(KEEP_OFF_ADD);
            oldest_reg   <= '0;
            count_reg    <= '0;
            k_reg        <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            delay_reg    <= delay_next;
            keep_off_reg <= keep_off_next;
            oldest_reg   <= oldest_next;
            count_reg    <= count_next;
            k_reg        <= k_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_lin_reg   <= in_lin_next;
        in_ang_reg   <= in_ang_next;
        now_reg      <= now_next;
        active_reg   <= active_next;
        ovf_reg      <= ovf_next;
        res_lin_reg  <= res_lin_next;
        res_ang_reg  <= res_ang_next;
        res_time_reg <= res_time_next;
        if (out_load) begin
            m_lin_reg      <= res_lin_reg;
            m_ang_reg      <= res_ang_reg;
            m_time_reg     <= res_time_reg;
            m_delay_on_reg <= active_reg;
            m_echo_lin_reg <= in_lin_reg;
            m_echo_ang_reg <= in_ang_reg;
            m_ovf_reg      <= ovf_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_delayed_linear  = m_lin_reg;
    assign m_delayed_angular = m_ang_reg;
    assign m_source_time_us  = m_time_reg;
    assign m_delay_on        = m_delay_on_reg;
    assign m_echo_linear     = m_echo_lin_reg;
    assign m_echo_angular    = m_echo_ang_reg;
    assign m_ring_overflow   = m_ovf_reg;

    `ASSERT_HOLDS(a_count_bound, count_reg <= CNT_W'(HIST_DEPTH), "history count above depth")
    `ASSERT_NEXT(a_cfg_clr, cfg_valid && cfg_ready, count_reg == '0, "history kept")
    `ASSERT_NEXT(a_accept_seq, s_valid && s_ready, state_reg != ST_IDLE, "accept left idle")
    `ASSERT_HOLDS(a_rise, $rose(m_valid_reg) |-> $past(state_reg == ST_DONE), "stray valid")

endmodule
